// File: hdl/shp_pkg.sv
// Shared types, constants and the mean-key helper for the successive halving pruner.
`timescale 1ns / 1ps

package shp_pkg;

    localparam int MAX_CAND  = 64;
    localparam int IDX_W     = 6;
    localparam int NUM_W     = 7;
    localparam int SUM_W     = 48;
    localparam int EVAL_W    = 32;
    localparam int SCORE_W   = 32;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_REPORT     = 3'd0;
    localparam t_cmd CMD_PRUNE_RATE = 3'd1;
    localparam t_cmd CMD_PRUNE_KEEP = 3'd2;
    localparam t_cmd CMD_LIST       = 3'd3;
    localparam t_cmd CMD_ASK        = 3'd4;
    localparam t_cmd CMD_CLEAR      = 3'd5;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CAND_COUNT = 2'd0;
    localparam t_cfg_idx CFG_MAXIMIZE   = 2'd1;
    localparam t_cfg_idx CFG_RATE       = 2'd2;

    // Sign codes, ordered so that a larger code means a larger mean.
    typedef logic [1:0] t_sgn;

    localparam t_sgn SG_NEG  = 2'd0;
    localparam t_sgn SG_ZERO = 2'd1;
    localparam t_sgn SG_POS  = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [EVAL_W-1:0] cnt;
    } t_entry;

    // Comparison key of one candidate: sign, magnitude of sum, count.
    typedef struct packed {
        logic [SUM_W-1:0]  mag;
        logic [EVAL_W-1:0] cnt;
        t_sgn              sgn;
        logic [IDX_W-1:0]  idx;
    } t_ref;

    function automatic t_ref make_ref(input t_entry e, input logic v,
                                      input logic [IDX_W-1:0] idx);
        t_ref             r;
        logic             use_it;
        logic [SUM_W-1:0] s;
        use_it = v && (e.cnt != '0);
        s      = use_it ? e.sum : '0;
        r.cnt  = use_it ? e.cnt : EVAL_W'(1);
        r.sgn  = s[SUM_W-1] ? SG_NEG : ((s == '0) ? SG_ZERO : SG_POS);
        r.mag  = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
        r.idx  = idx;
        return r;
    endfunction

endpackage

// File: hdl/shp_rank_cmp.sv
// Pipelined mean comparator: decides whether a streamed candidate outranks the held one.
`timescale 1ns / 1ps

module shp_rank_cmp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_issue,
    input  logic [shp_pkg::IDX_W-1:0] i_j,
    input  logic                      i_cand,
    input  shp_pkg::t_entry           i_rd_ent,
    input  logic                      i_rd_vld,
    input  shp_pkg::t_ref             i_ref,
    input  logic                      i_maximize,
    output logic                      o_busy,
    output logic                      o_hit
);
    import shp_pkg::*;

    localparam int HI_W   = SUM_W - 32;
    localparam int PLO_W  = 32 + EVAL_W;
    localparam int PHI_W  = HI_W + EVAL_W;
    localparam int PROD_W = SUM_W + EVAL_W;

    logic             r_v0, r_v1, r_v2, r_v3;
    logic             r_c0, r_c1, r_c2, r_c3;
    logic [IDX_W-1:0] r_j0;
    t_ref             r_a1;
    t_sgn             r_s2, r_s3;
    logic [IDX_W-1:0] r_j2, r_j3;
    logic [PLO_W-1:0] r_pa_lo, r_pb_lo;
    logic [PHI_W-1:0] r_pa_hi, r_pb_hi;
    logic [PROD_W-1:0] r_pa, r_pb;

    logic w_gt, w_lt, w_cgt, w_clt, w_beats;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= i_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_j0 <= i_j;
        r_c0 <= i_cand;
        // key of the streamed candidate, memory data arrives this cycle
        r_a1 <= make_ref(i_rd_ent, i_rd_vld, r_j0);
        r_c1 <= r_c0;
        // cross products split into the low 32 bits and the high bits of the magnitude
        r_pa_lo <= PLO_W'(r_a1.mag[31:0]) * PLO_W'(i_ref.cnt);
        r_pa_hi <= PHI_W'(r_a1.mag[SUM_W-1:32]) * PHI_W'(i_ref.cnt);
        r_pb_lo <= PLO_W'(i_ref.mag[31:0]) * PLO_W'(r_a1.cnt);
        r_pb_hi <= PHI_W'(i_ref.mag[SUM_W-1:32]) * PHI_W'(r_a1.cnt);
        r_s2    <= r_a1.sgn;
        r_j2    <= r_a1.idx;
        r_c2    <= r_c1;
        r_pa    <= {r_pa_hi, 32'b0} + PROD_W'(r_pa_lo);
        r_pb    <= {r_pb_hi, 32'b0} + PROD_W'(r_pb_lo);
        r_s3    <= r_s2;
        r_j3    <= r_j2;
        r_c3    <= r_c2;
    end

    always_comb begin
        w_gt = r_pa > r_pb;
        w_lt = r_pa < r_pb;
        if (r_s3 != i_ref.sgn) begin
            w_cgt = r_s3 > i_ref.sgn;
            w_clt = r_s3 < i_ref.sgn;
        end else if (r_s3 == SG_ZERO) begin
            w_cgt = 1'b0;
            w_clt = 1'b0;
        end else if (r_s3 == SG_POS) begin
            w_cgt = w_gt;
            w_clt = w_lt;
        end else begin
            w_cgt = w_lt;
            w_clt = w_gt;
        end
        if (w_cgt || w_clt) begin
            w_beats = i_maximize ? w_cgt : w_clt;
        end else begin
            w_beats = r_j3 < i_ref.idx;
        end
    end

    assign o_hit  = r_v3 && r_c3 && w_beats;
    assign o_busy = r_v0 || r_v1 || r_v2 || r_v3;

endmodule

// File: hdl/successive_halving_pruner_unit.sv
// Top level of the successive halving pruner: command sequencer, candidate memory, output stage.
`timescale 1ns / 1ps

// Successive halving pruner. Holds 64 candidates, each with a saturating
// 48-bit score sum and 32-bit evaluation count in one synchronous memory
// (one read, one write per cycle), plus an active flag in flip-flops. A
// report is one read-modify-write. A list walks the ids in order, one per
// cycle while the output beat is free, up to the last survivor. A prune
// first works out the keep count (a rate prune subtracts the rate once per
// cycle); if fewer are kept than are alive, it then for each active
// candidate streams all 64 entries through the memory read port and a
// four-stage cross-multiply comparator, followed by the survivor listing.
// Results leave through a registered output beat, so the next command is
// taken while the last result of the previous one still waits. Memory
// entries carry a valid bit that reset and clear drop, so no clearing pass
// is needed. Configuration writes are always accepted.
module successive_halving_pruner_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [shp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [shp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [shp_pkg::CMD_W-1:0]     i_command,
    input  logic [shp_pkg::IDX_W-1:0]     i_id,
    input  logic signed [shp_pkg::SCORE_W-1:0] i_score,
    input  logic [shp_pkg::NUM_W-1:0]     i_keep_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [shp_pkg::IDX_W-1:0]     o_survivor_id,
    output logic                          o_id_valid,
    output logic                          o_alive,
    output logic [shp_pkg::NUM_W-1:0]     o_survivor_count,
    output logic                          o_last
);
    import shp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RPT, ST_ONE, ST_DIV, ST_CHK, ST_PLD, ST_PLW,
        ST_PRUN, ST_PDRN, ST_APPLY, ST_LIST
    } t_state;

    t_state r_state;

    // configuration
    logic [NUM_W-1:0] r_cand_count;
    logic             r_maximize;
    logic [NUM_W-1:0] r_rate;

    // latched command
    t_cmd                r_cmd;
    logic [IDX_W-1:0]    r_id;
    logic [SCORE_W-1:0]  r_score;
    logic [NUM_W-1:0]    r_keep;

    // table state outside the memory
    logic [MAX_CAND-1:0] r_act;
    logic [MAX_CAND-1:0] r_vld;
    logic [MAX_CAND-1:0] r_drop;
    logic [NUM_W-1:0]    r_alive_total;

    // sequencer counters
    logic [NUM_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_k;
    logic [NUM_W-1:0] r_seen;
    logic [NUM_W-1:0] r_rank;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    t_ref             r_ref;

    // memory
    t_entry r_mem [MAX_CAND];
    t_entry r_rd_data;
    logic   r_rd_vld;

    // output beat
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_sid;
    logic             r_out_idv;
    logic             r_out_alive;
    logic [NUM_W-1:0] r_out_cnt;
    logic             r_out_last;

    logic             w_in_acc;
    logic             w_out_free;
    logic             w_emit;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_wr_en;
    t_entry           w_wr_ent;
    logic [NUM_W-1:0] w_sat_n;
    logic [NUM_W-1:0] w_rate;
    logic [SUM_W-1:0] w_cur_sum;
    logic [EVAL_W-1:0] w_cur_cnt;
    logic [SUM_W:0]   w_sum_x;
    logic             w_busy;
    logic             w_hit;
    logic             w_issue;
    logic             w_cand;
    logic             w_list_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // A new output beat is loaded this cycle.
    assign w_emit = w_out_free && ((r_state == ST_RPT) || (r_state == ST_ONE) ||
                    ((r_state == ST_LIST) && ((r_alive_total == '0) || r_act[r_k])));

    // Saturate the applied candidate count to 1..MAX_CAND; zero rate acts as 1.
    assign w_sat_n = (r_cand_count == '0) ? NUM_W'(1) :
                     (r_cand_count > NUM_W'(MAX_CAND)) ? NUM_W'(MAX_CAND) : r_cand_count;
    assign w_rate  = (r_rate == '0) ? NUM_W'(1) : r_rate;

    // Read-modify-write of one report: saturating sum, sticky-max count.
    always_comb begin
        w_cur_sum = r_rd_vld ? r_rd_data.sum : '0;
        w_cur_cnt = r_rd_vld ? r_rd_data.cnt : '0;
        w_sum_x   = {w_cur_sum[SUM_W-1], w_cur_sum}
                  + {{(SUM_W + 1 - SCORE_W){r_score[SCORE_W-1]}}, r_score};
        if (w_sum_x[SUM_W] != w_sum_x[SUM_W-1]) begin
            w_wr_ent.sum = w_sum_x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                          : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_wr_ent.sum = w_sum_x[SUM_W-1:0];
        end
        w_wr_ent.cnt = (w_cur_cnt == '1) ? w_cur_cnt : w_cur_cnt + EVAL_W'(1);
        w_wr_en      = (r_state == ST_RPT) && w_out_free && r_act[r_id];
    end

    // Memory read port: report address, held candidate, or streamed rival.
    always_comb begin
        w_issue   = (r_state == ST_PRUN);
        w_cand    = r_act[r_j] && (r_j != r_i[IDX_W-1:0]);
        w_rd_en   = 1'b0;
        w_rd_addr = r_j;
        if (w_in_acc && (i_command == CMD_REPORT)) begin
            w_rd_en   = 1'b1;
            w_rd_addr = i_id;
        end else if ((r_state == ST_PLD) && (r_i != NUM_W'(MAX_CAND))
                     && r_act[r_i[IDX_W-1:0]]) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_i[IDX_W-1:0];
        end else if (w_issue) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_j;
        end
    end

    assign w_list_last = (r_seen + NUM_W'(1)) == r_alive_total;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_id] <= w_wr_ent;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_vld  <= r_vld[w_rd_addr];
        end
    end

    shp_rank_cmp u_cmp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_issue    (w_issue),
        .i_j        (r_j),
        .i_cand     (w_cand),
        .i_rd_ent   (r_rd_data),
        .i_rd_vld   (r_rd_vld),
        .i_ref      (r_ref),
        .i_maximize (r_maximize),
        .o_busy     (w_busy),
        .o_hit      (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cand_count  <= NUM_W'(MAX_CAND);
            r_maximize    <= 1'b1;
            r_rate        <= NUM_W'(2);
            r_act         <= '1;
            r_vld         <= '0;
            r_alive_total <= NUM_W'(MAX_CAND);
            r_out_valid   <= 1'b0;
        end else begin
            // configuration writes land regardless of the sequencer
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CAND_COUNT: r_cand_count <= i_cfg_data;
                    CFG_MAXIMIZE:   r_maximize   <= i_cfg_data[0];
                    CFG_RATE:       r_rate       <= i_cfg_data;
                    default: ;
                endcase
            end

            // drop the output beat once taken; an emit below refills it
            if (i_out_ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end

            if (w_hit) begin
                r_rank <= r_rank + NUM_W'(1);
            end

            if (w_wr_en) begin
                r_vld[r_id] <= 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd   <= i_command;
                        r_id    <= i_id;
                        r_score <= i_score;
                        r_keep  <= i_keep_count;
                        r_k     <= '0;
                        r_seen  <= '0;
                        r_rem   <= r_alive_total;
                        r_quo   <= '0;
                        case (i_command)
                            CMD_REPORT:     r_state <= ST_RPT;
                            CMD_PRUNE_RATE: r_state <= ST_DIV;
                            CMD_PRUNE_KEEP: r_state <= ST_CHK;
                            CMD_LIST:       r_state <= ST_LIST;
                            default:        r_state <= ST_ONE;
                        endcase
                    end
                end
                ST_RPT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_sid   <= '0;
                        r_out_idv   <= 1'b0;
                        r_out_alive <= r_act[r_id];
                        r_out_cnt   <= r_alive_total;
                        r_out_last  <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_ONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_sid   <= '0;
                        r_out_idv   <= 1'b0;
                        r_out_alive <= (r_cmd == CMD_ASK) ? r_act[r_id] : 1'b0;
                        r_out_cnt   <= (r_cmd == CMD_CLEAR) ? w_sat_n : r_alive_total;
                        r_out_last  <= 1'b1;
                        if (r_cmd == CMD_CLEAR) begin
                            r_vld         <= '0;
                            r_alive_total <= w_sat_n;
                            for (int k = 0; k < MAX_CAND; k++) begin
                                r_act[k] <= (NUM_W'(k) < w_sat_n);
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    // one subtract of the rate per cycle
                    if (r_rem >= w_rate) begin
                        r_rem <= r_rem - w_rate;
                        r_quo <= r_quo + NUM_W'(1);
                    end else begin
                        r_keep  <= (r_quo == '0) ? NUM_W'(1) : r_quo;
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    r_i    <= '0;
                    r_drop <= '0;
                    if (r_keep >= r_alive_total) begin
                        r_state <= ST_LIST;
                    end else begin
                        r_state <= ST_PLD;
                    end
                end
                ST_PLD: begin
                    if (r_i == NUM_W'(MAX_CAND)) begin
                        r_state <= ST_APPLY;
                    end else if (!r_act[r_i[IDX_W-1:0]]) begin
                        r_i <= r_i + NUM_W'(1);
                    end else begin
                        r_state <= ST_PLW;
                    end
                end
                ST_PLW: begin
                    r_ref   <= make_ref(r_rd_data, r_rd_vld, r_i[IDX_W-1:0]);
                    r_rank  <= '0;
                    r_j     <= '0;
                    r_state <= ST_PRUN;
                end
                ST_PRUN: begin
                    r_j <= r_j + IDX_W'(1);
                    if (r_j == IDX_W'(MAX_CAND - 1)) begin
                        r_state <= ST_PDRN;
                    end
                end
                ST_PDRN: begin
                    // wait for the comparator to flush, then rank is final
                    if (!w_busy) begin
                        r_drop[r_i[IDX_W-1:0]] <= (r_rank >= r_keep);
                        r_i     <= r_i + NUM_W'(1);
                        r_state <= ST_PLD;
                    end
                end
                ST_APPLY: begin
                    r_act         <= r_act & ~r_drop;
                    r_alive_total <= r_keep;
                    r_state       <= ST_LIST;
                end
                ST_LIST: begin
                    if (r_alive_total == '0) begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_sid   <= '0;
                            r_out_idv   <= 1'b0;
                            r_out_alive <= 1'b0;
                            r_out_cnt   <= r_alive_total;
                            r_out_last  <= 1'b1;
                            r_state     <= ST_IDLE;
                        end
                    end else if (r_act[r_k]) begin
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_sid   <= r_k;
                            r_out_idv   <= 1'b1;
                            r_out_alive <= 1'b1;
                            r_out_cnt   <= r_alive_total;
                            r_out_last  <= w_list_last;
                            r_seen      <= r_seen + NUM_W'(1);
                            r_k         <= r_k + IDX_W'(1);
                            if (w_list_last) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end else begin
                        r_k <= r_k + IDX_W'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_survivor_id    = r_out_sid;
    assign o_id_valid       = r_out_idv;
    assign o_alive          = r_out_alive;
    assign o_survivor_count = r_out_cnt;
    assign o_last           = r_out_last;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alive_total <= NUM_W'(MAX_CAND))
        else $error("survivor total beyond table size");

    a_flags_match_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(r_act) == int'(r_alive_total)))
        else $error("active flags disagree with survivor total");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("second command taken while one is in flight");

    a_no_write_in_prune: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_wr_en)
        else $error("memory written while comparator streams entries");
`endif

endmodule
